FILE: hw/rtl/bbfd_pkg.sv
// Package with the shared types and constants of the brace-balanced frame delimiter.
package bbfd_pkg;

    // Frame buffer size: a frame holds at most FRAME_BYTES-1 bytes.
    localparam int FRAME_BYTES = 256;
    localparam logic [7:0] FRAME_LIMIT = 8'(FRAME_BYTES - 1);

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    // Configuration port geometry: registers at byte addresses 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic
    {
        REG_REBOOT_ENABLE = 1'b0,
        REG_REBOOT_CODE   = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic       reboot_enable;
        logic [7:0] reboot_code;
    } cfg_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       frame_member;
        logic       frame_first;
        logic       frame_last;
        logic       frame_overflow;
        logic [7:0] frame_length;
        logic       reboot_request;
    } result_t;

endpackage

FILE: hw/rtl/bbfd_ifaces.sv
// Valid/ready channel interfaces for received bytes and framed results.
interface bbfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bbfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_member;
    logic       frame_first;
    logic       frame_last;
    logic       frame_overflow;
    logic [7:0] frame_length;
    logic       reboot_request;

    modport source (
        output valid, output out_byte, output frame_member, output frame_first,
        output frame_last, output frame_overflow, output frame_length,
        output reboot_request, input ready
    );
    modport sink (
        input valid, input out_byte, input frame_member, input frame_first,
        input frame_last, input frame_overflow, input frame_length,
        input reboot_request, output ready
    );
endinterface

FILE: hw/rtl/bbfd_cfg_regs.sv
// APB configuration registers: reboot enable and reboot code.
module bbfd_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bbfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bbfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output bbfd_pkg::cfg_t                    cfg
);

    bbfd_pkg::cfg_t       cfg_reg;
    bbfd_pkg::cfg_t       cfg_next;
    bbfd_pkg::reg_index_t reg_sel;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = bbfd_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                bbfd_pkg::REG_REBOOT_ENABLE: cfg_next.reboot_enable = pwdata[0];
                bbfd_pkg::REG_REBOOT_CODE:   cfg_next.reboot_code   = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bbfd_pkg::REG_REBOOT_ENABLE:
                prdata = {{(bbfd_pkg::APB_DATA_W-1){1'b0}}, cfg_reg.reboot_enable};
            bbfd_pkg::REG_REBOOT_CODE:
                prdata = {{(bbfd_pkg::APB_DATA_W-8){1'b0}}, cfg_reg.reboot_code};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reboot_enable <= 1'b1;
            cfg_reg.reboot_code   <= 8'h00;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/bbfd_core.sv
// Framing state (collecting, depth, count) and the per-byte result logic.
module bbfd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    input  bbfd_pkg::cfg_t      cfg,
    output bbfd_pkg::result_t   res
);

    logic       collecting_reg;
    logic       collecting_next;
    logic [7:0] depth_reg;
    logic [7:0] depth_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;
    logic [7:0] depth_upd;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        if (rx_byte == bbfd_pkg::OPEN_BRACE)
            depth_upd = depth_reg + 8'd1;
        else if (rx_byte == bbfd_pkg::CLOSE_BRACE)
            depth_upd = depth_reg - 8'd1;
        else
            depth_upd = depth_reg;
    end

    always_comb
    begin
        res                = '0;
        res.out_byte       = rx_byte;
        collecting_next    = collecting_reg;
        depth_next         = depth_reg;
        count_next         = count_reg;

        if (!collecting_reg)
        begin
            if (rx_byte == bbfd_pkg::OPEN_BRACE)
            begin
                collecting_next  = 1'b1;
                depth_next       = 8'd1;
                count_next       = 8'd1;
                res.frame_member = 1'b1;
                res.frame_first  = 1'b1;
                res.frame_length = 8'd1;
            end
            else if (cfg.reboot_enable && rx_byte == cfg.reboot_code)
            begin
                res.reboot_request = 1'b1;
            end
        end
        else if (count_reg < bbfd_pkg::FRAME_LIMIT)
        begin
            depth_next       = depth_upd;
            count_next       = count_inc;
            res.frame_member = 1'b1;
            res.frame_length = count_inc;
            if (depth_upd == 8'd0)
            begin
                res.frame_last  = 1'b1;
                collecting_next = 1'b0;
                count_next      = 8'd0;
            end
        end
        else
        begin
            // Limit reached: the byte is dropped and the frame is aborted.
            res.frame_overflow = 1'b1;
            res.frame_length   = count_reg;
            collecting_next    = 1'b0;
            depth_next         = 8'd0;
            count_next         = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            depth_reg      <= 8'd0;
            count_reg      <= 8'd0;
        end
        else if (advance)
        begin
            collecting_reg <= collecting_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
        end
    end

endmodule

FILE: hw/rtl/brace_balanced_frame_delimiter.sv
// Path: an accepted byte is registered in stage 1, and its result is then registered
// in the result register that drives frame_out.
// Throughput: one byte per cycle; the input register feeds the framing logic
// and the result register, and both stages advance together when frame_out flows.
// Reset (rst_n, asynchronous, active low) empties both stages, returns the
// framer to idle with depth and count zero, and sets reboot_enable=1, reboot_code=0.
// Top level of the brace-balanced frame delimiter.
module brace_balanced_frame_delimiter
(
    input  logic                              clk,
    input  logic                              rst_n,
    bbfd_byte_if.sink                         byte_in,
    bbfd_frame_if.source                      frame_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bbfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bbfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bbfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    bbfd_pkg::cfg_t    cfg;
    bbfd_pkg::result_t core_res;

    // Stage 1: the accepted byte waits here for the framing logic.
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    // Stage 2: the finished result waits here for the sink.
    logic              out_valid_reg;
    bbfd_pkg::result_t out_res_reg;

    logic out_free;
    logic s1_advance;
    logic in_fire;

    bbfd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The framing state moves only when the byte in stage 1 is handed on to
    // the result register, so every byte is seen exactly once and in order.
    bbfd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .rx_byte (s1_byte_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // The result register can take a new result when it is empty or its
    // current transaction completes this cycle.
    assign out_free   = !out_valid_reg || frame_out.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign byte_in.ready = !s1_valid_reg || out_free;
    assign in_fire    = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
                s1_valid_reg <= byte_in.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_byte_reg <= byte_in.rx_byte;
        if (s1_advance)
            out_res_reg <= core_res;
    end

    assign frame_out.valid          = out_valid_reg;
    assign frame_out.out_byte       = out_res_reg.out_byte;
    assign frame_out.frame_member   = out_res_reg.frame_member;
    assign frame_out.frame_first    = out_res_reg.frame_first;
    assign frame_out.frame_last     = out_res_reg.frame_last;
    assign frame_out.frame_overflow = out_res_reg.frame_overflow;
    assign frame_out.frame_length   = out_res_reg.frame_length;
    assign frame_out.reboot_request = out_res_reg.reboot_request;

    // A frame start is always a member byte of length one.
    a_first_is_member: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.frame_first) |->
            (out_res_reg.frame_member && out_res_reg.frame_length == 8'd1))
        else $error("frame start without membership or with wrong length");

    // An aborted frame drops its byte and reports a full buffer.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.frame_overflow) |->
            (!out_res_reg.frame_member && out_res_reg.frame_length == bbfd_pkg::FRAME_LIMIT))
        else $error("overflow reported before the length limit");

    // A reboot request only comes from an idle, non-member byte.
    a_reboot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.reboot_request) |->
            (!out_res_reg.frame_member && out_res_reg.frame_length == 8'd0))
        else $error("reboot request raised inside a frame");

    // A result that has not been taken is held in the result register.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_out.ready) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("pending result changed before it was taken");

endmodule

FILE: verif/brace_balanced_frame_delimiter_test.sv
// Self-checking testbench for the brace-balanced frame delimiter: directed cases plus random frames.
`timescale 1ns / 1ps

module brace_balanced_frame_delimiter_test;

    import bbfd_pkg::*;

    // The watchdog ends the run after this many cycles without any transaction.
    localparam int WATCHDOG_LIMIT = 2000;
    // Normal random items per idling phase; the two long frames come on top.
    localparam int PHASE_ITEMS = 25;
    // Cycles to wait after the last result before the run ends.
    localparam int SETTLE_CYCLES = 10;

    // The scoreboard keeps its own copy of the framer state and configuration.
    // Every accepted byte yields exactly one expected framed byte, queued in order.
    class frame_scoreboard;
        logic       reboot_on;
        logic [7:0] reboot_byte;
        logic       in_frame;
        logic [7:0] depth;
        logic [7:0] kept;
        result_t    framed_bytes_due[$];
        int         errors;

        function new();
            reboot_on   = 1'b1;
            reboot_byte = 8'h00;
            in_frame    = 1'b0;
            depth       = 8'h00;
            kept        = 8'h00;
            errors      = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            if (idx == REG_REBOOT_ENABLE)
                reboot_on = value[0];
            else
                reboot_byte = value[7:0];
        endfunction

        function string describe(result_t r);
            return $sformatf({"byte=%02h member=%b first=%b last=%b overflow=%b ",
                              "length=%0d reboot=%b"},
                             r.out_byte, r.frame_member, r.frame_first, r.frame_last,
                             r.frame_overflow, r.frame_length, r.reboot_request);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            result_t r;
            r = '0;
            r.out_byte = b;
            if (!in_frame)
            begin
                // An opening brace wins over a matching reboot code.
                if (b == OPEN_BRACE)
                begin
                    in_frame         = 1'b1;
                    depth            = 8'd1;
                    kept             = 8'd1;
                    r.frame_member   = 1'b1;
                    r.frame_first    = 1'b1;
                    r.frame_length   = 8'd1;
                end
                else if (reboot_on && b == reboot_byte)
                begin
                    r.reboot_request = 1'b1;
                end
            end
            else if (kept < FRAME_LIMIT)
            begin
                kept = kept + 8'd1;
                if (b == OPEN_BRACE)
                    depth = depth + 8'd1;
                else if (b == CLOSE_BRACE)
                    depth = depth - 8'd1;
                r.frame_member = 1'b1;
                r.frame_length = kept;
                if (depth == 8'd0)
                begin
                    r.frame_last = 1'b1;
                    in_frame     = 1'b0;
                    kept         = 8'd0;
                end
            end
            else
            begin
                // The frame is full: the byte is dropped unexamined and the frame aborted.
                r.frame_overflow = 1'b1;
                r.frame_length   = kept;
                in_frame         = 1'b0;
                depth            = 8'd0;
                kept             = 8'd0;
            end
            framed_bytes_due.push_back(r);
        endfunction

        function void check_framed_byte(result_t got);
            result_t want;
            if (framed_bytes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected framed byte: expected none, actual %s",
                         $time, describe(got));
                return;
            end
            want = framed_bytes_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: framed byte mismatch: expected %s, actual %s",
                         $time, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bbfd_byte_if  byte_in ();
    bbfd_frame_if frame_out ();

    brace_balanced_frame_delimiter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .frame_out (frame_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    frame_scoreboard sb;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides its ready for the next edge at every falling edge,
    // so a stall can land on any phase of the pipeline.
    always @(negedge clk)
    begin
        frame_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both channels are sampled at the rising edge. The output is checked before
    // the input is noted; with two pipeline stages between them they never refer to the same byte.
    always @(posedge clk)
    begin : monitor
        result_t got;
        logic    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (frame_out.valid && frame_out.ready)
            begin
                got.out_byte       = frame_out.out_byte;
                got.frame_member   = frame_out.frame_member;
                got.frame_first    = frame_out.frame_first;
                got.frame_last     = frame_out.frame_last;
                got.frame_overflow = frame_out.frame_overflow;
                got.frame_length   = frame_out.frame_length;
                got.reboot_request = frame_out.reboot_request;
                sb.check_framed_byte(got);
                moved = 1'b1;
            end
            if (byte_in.valid && byte_in.ready)
            begin
                sb.note_rx_byte(byte_in.rx_byte);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offers one byte, with random idle cycles first, and returns at the falling
    // edge after the transaction with valid still high. Entered at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(negedge clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_in.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every expected framed byte has come out.
    task automatic drain_results();
        byte_in.valid <= 1'b0;
        @(negedge clk);
        while (sb.framed_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at
    // the rising edge where the access completes. Entered at a falling edge.
    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every byte yields a result, so an empty queue plus the pipeline depth
    // means the block is idle and its registers may be rewritten.
    task automatic configure(input logic enable, input logic [7:0] code);
        drain_results();
        repeat (3) @(negedge clk);
        write_register(REG_REBOOT_ENABLE, {31'd0, enable});
        @(negedge clk);
        write_register(REG_REBOOT_CODE, {24'd0, code});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == OPEN_BRACE || b == CLOSE_BRACE)
            b = b ^ 8'h01;
        return b;
    endfunction

    // Frame content is brace heavy so that nesting gets exercised; quotes are
    // mixed in because braces inside strings count like any other brace.
    function automatic logic [7:0] content_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return OPEN_BRACE;
        else if (pick < 40)
            return CLOSE_BRACE;
        else if (pick < 50)
            return 8'h22;
        return 8'($urandom_range(255));
    endfunction

    // Sends a well-formed frame: an opening brace, random content that never
    // closes the outer level early, then enough closing braces to balance it.
    task automatic send_frame(input int body);
        int         level;
        logic [7:0] b;
        level = 1;
        send_byte(OPEN_BRACE);
        repeat (body)
        begin
            b = content_byte();
            if (b == CLOSE_BRACE && level == 1)
                b = 8'h22;
            if (b == OPEN_BRACE)
                level++;
            else if (b == CLOSE_BRACE)
                level--;
            send_byte(b);
        end
        while (level > 0)
        begin
            send_byte(CLOSE_BRACE);
            level--;
        end
    endtask

    // Bytes between frames, biased toward the reboot code and stray closing braces.
    task automatic send_noise(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_byte(sb.reboot_byte);
            else if (pick < 60)
                send_byte(CLOSE_BRACE);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    // A frame that starts but never closes; following bytes join it until a
    // later brace balances it or the length limit aborts it.
    task automatic send_broken_frame(input int count);
        send_byte(OPEN_BRACE);
        repeat (count)
            send_byte(8'($urandom_range(255)));
    endtask

    // A frame at the length limit. Without overflow it closes on exactly the
    // largest allowed length; with overflow the closing brace is one byte too many
    // and must be dropped without ending the frame as a close.
    task automatic send_long_frame(input bit overflow);
        while (sb.in_frame)
            send_byte(CLOSE_BRACE);
        send_byte(OPEN_BRACE);
        repeat (int'(FRAME_LIMIT) - 2 + int'(overflow))
            send_byte(plain_byte());
        send_byte(CLOSE_BRACE);
        send_byte(OPEN_BRACE);
        send_byte(CLOSE_BRACE);
    endtask

    task automatic run_random_phase(input int phase);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame($urandom_range(0, 14));
            else if (pick < 88)
                send_noise($urandom_range(1, 6));
            else
                send_broken_frame($urandom_range(1, 6));
            // Halfway through, the sender holds off until the output is empty.
            if (bytes_sent - start >= PHASE_ITEMS / 2 && bytes_sent - start < PHASE_ITEMS / 2 + 4)
                drain_results();
        end
        if (phase == 1)
            send_long_frame(1'b0);
        else if (phase == 3)
            send_long_frame(1'b1);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        bytes_sent      = 0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        byte_in.valid   = 1'b0;
        byte_in.rx_byte = 8'h00;
        frame_out.ready = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset configuration: reboot enabled, code zero.
        send_byte(8'h00);           // reboot request while idle
        send_byte(8'hFF);           // idle byte outside any frame
        send_byte(CLOSE_BRACE);     // stray closing brace while idle
        send_byte(OPEN_BRACE);      // frame start
        send_byte(8'h00);           // reboot code inside a frame is just content
        send_byte(OPEN_BRACE);
        send_byte(8'hFF);
        send_byte(CLOSE_BRACE);
        send_byte(CLOSE_BRACE);     // frame complete
        send_byte(OPEN_BRACE);      // byte right after the close starts a new frame
        send_byte(CLOSE_BRACE);
        send_byte(8'h00);           // and the idle byte after it is not swallowed
        // A reboot code equal to the opening brace: the brace must win.
        configure(1'b1, OPEN_BRACE);
        send_byte(OPEN_BRACE);
        send_byte(CLOSE_BRACE);
        // Reboot disabled: the code byte passes without a request.
        configure(1'b0, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        configure(1'b1, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);

        // Random part over four idling phases, each with its own register setting.
        for (int phase = 0; phase < 4; phase++)
        begin
            configure(phase != 1, (phase == 2) ? 8'hFF : 8'($urandom_range(255)));
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            run_random_phase(phase);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
